// ===== rtl/core/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and constants for the aging priority scheduler.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int unsigned MAX_TASKS_DEF = 16;
    localparam int unsigned IDX_W         = 6;
    localparam int unsigned PRI_W         = 24;
    localparam int unsigned W16           = 16;
    localparam logic [15:0] TIME_LIMIT_RST = 16'd10000;
    localparam logic [15:0] W16_MAX       = 16'hFFFF;
    localparam logic signed [PRI_W:0] PRI_MAX = 25'sh07FFFFF;

    localparam logic REG_AGING_STEP = 1'b0;
    localparam logic REG_TIME_LIMIT = 1'b1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // best candidate carried down the chain of cells
    typedef struct packed {
        logic                    found;
        logic signed [PRI_W-1:0] prio;
        logic [15:0]             arrival;
        logic [IDX_W-1:0]        idx;
        logic [15:0]             id;
        logic                    started;
        logic [15:0]             start;
        logic [15:0]             wait_cnt;
        logic [15:0]             remaining;
    } cand_t;

    // broadcast to all cells in the update cycle
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] sel;
        logic [15:0]      now;
        logic [15:0]      aging;
    } upd_t;

endpackage

// ===== rtl/core/aging_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// aging_priority_scheduler
// Preemptive priority scheduler with aging over a chain of task cells.
// ----------------------------------------------------------------------------
//  port group  dir  contents
//  s_axis      in   tuser: mode; tdata: task_id, task_priority, arrival, burst
//  m_axis      out  tdata: tick result, one beat per tick beat
//  apb         in   aging_step @0x0, time_limit @0x4
//
//  A load beat is taken in the idle state. A tick beat walks the candidate
//  down the cell chain one cell per cycle, then passes the update state
//  and the output state. A tick after all_done goes straight to output.
//  Reset clears cell valid/started bits, counters, state and APB registers.
//  A stalled m_axis beat holds; one more tick can finish and wait for the
//  output register, and s_tready stays low until that beat moves on.
// ----------------------------------------------------------------------------
module aging_priority_scheduler #(
    parameter int unsigned MAX_TASKS = aps_pkg::MAX_TASKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // task_id[15:0], task_priority[39:16],
                                   // arrival_time[55:40], burst_length[71:56]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // tick_time, running_valid, running_id, finished,
                                   // response_time, waiting_total,
                                   // turnaround_time, all_done, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import aps_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
    localparam int unsigned SC_W  = $clog2(MAX_TASKS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);
    localparam logic [SC_W-1:0]  SC_LAST = SC_W'(MAX_TASKS - 1);

    typedef enum logic [1:0] { ST_IDLE, ST_SCAN, ST_UPD, ST_OUT } state_t;

    state_t           state_reg;
    logic [SC_W-1:0]  scan_reg;
    logic [CNT_W-1:0] loaded_reg;
    logic [CNT_W-1:0] completed_reg;
    logic [15:0]      time_reg;
    logic [15:0]      aging_reg;
    logic [15:0]      limit_reg;
    logic             m_tvalid_reg;
    logic [82:0]      res_reg;
    logic [82:0]      m_data_reg;

    cand_t            chain [MAX_TASKS+1];
    cand_t            win;
    upd_t             upd;
    logic             acc;
    logic             done_now;
    logic             wr;
    logic [15:0]      time_next;
    logic [CNT_W-1:0] completed_next;
    logic             fin;
    logic [15:0]      start_eff;

    assign pready   = 1'b1;
    assign wr       = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_TIME_LIMIT) ? {16'd0, limit_reg} : {16'd0, aging_reg};
    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_data_reg};
    assign done_now = (completed_reg == loaded_reg) || (time_reg >= limit_reg);

    assign chain[0] = '0;
    assign win      = chain[MAX_TASKS];

    assign upd.en    = (state_reg == ST_UPD) && win.found;
    assign upd.sel   = win.idx;
    assign upd.now   = time_reg;
    assign upd.aging = aging_reg;

    for (genvar k = 0; k < MAX_TASKS; k++)
    begin : g_cell
        aps_cell #(.INDEX(k)) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .load_en      (acc && (s_tuser == MODE_LOAD) && (loaded_reg == CNT_W'(k))),
            .load_id      (s_tdata[15:0]),
            .load_prio    (s_tdata[39:16]),
            .load_arrival (s_tdata[55:40]),
            .load_burst   (s_tdata[71:56]),
            .now          (time_reg),
            .upd          (upd),
            .cand_in      (chain[k]),
            .cand_out     (chain[k+1])
        );
    end

    assign time_next      = (time_reg != W16_MAX) ? time_reg + 16'd1 : time_reg;
    assign fin            = win.found && (win.remaining == 16'd1);
    assign completed_next = fin ? completed_reg + CNT_W'(1) : completed_reg;
    assign start_eff      = win.started ? win.start : time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aging_reg <= 16'd0;
            limit_reg <= TIME_LIMIT_RST;
        end
        else if (wr)
        begin
            if (paddr[2] == REG_TIME_LIMIT)
            begin
                limit_reg <= pwdata[15:0];
            end
            else
            begin
                aging_reg <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            loaded_reg    <= '0;
            completed_reg <= '0;
            time_reg      <= 16'd0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_OUT) && (!m_tvalid_reg || m_tready))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        if (s_tuser == MODE_LOAD)
                        begin
                            if (loaded_reg < MAX_CNT)
                            begin
                                loaded_reg <= loaded_reg + CNT_W'(1);
                            end
                        end
                        else if (done_now)
                        begin
                            res_reg   <= {1'b1, 66'd0, time_reg};
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            scan_reg  <= '0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    scan_reg <= scan_reg + SC_W'(1);
                    if (scan_reg == SC_LAST)
                    begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    time_reg      <= time_next;
                    completed_reg <= completed_next;
                    res_reg[15:0] <= time_reg;
                    res_reg[16]   <= win.found;
                    res_reg[32:17] <= win.found ? win.id : 16'd0;
                    res_reg[33]   <= fin;
                    res_reg[49:34] <= fin ? start_eff - win.arrival : 16'd0;
                    res_reg[65:50] <= fin ? win.wait_cnt : 16'd0;
                    res_reg[81:66] <= fin ? time_next - win.arrival : 16'd0;
                    res_reg[82]   <= (completed_next == loaded_reg) || (time_next >= limit_reg);
                    state_reg     <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_data_reg   <= res_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        completed_reg <= loaded_reg)
        else $error("completed count above loaded count");

    a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= MAX_CNT)
        else $error("loaded count above table size");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s_tuser == MODE_TICK) |=> !s_tready)
        else $error("input taken during a tick");

    a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_UPD) |=> $stable(time_reg))
        else $error("time moved outside the update cycle");

endmodule

// ===== rtl/core/aps_cell.sv =====
// ----------------------------------------------------------------------------
// aps_cell
// One task entry; merges its entry into the candidate and passes it on.
// ----------------------------------------------------------------------------
module aps_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load_en,
    input  logic [15:0]                load_id,
    input  logic [aps_pkg::PRI_W-1:0]  load_prio,
    input  logic [15:0]                load_arrival,
    input  logic [15:0]                load_burst,
    input  logic [15:0]                now,
    input  aps_pkg::upd_t              upd,
    input  aps_pkg::cand_t             cand_in,
    output aps_pkg::cand_t             cand_out
);
    import aps_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic                    valid_reg;
    logic [15:0]             id_reg;
    logic signed [PRI_W-1:0] prio_reg;
    logic [15:0]             arrival_reg;
    logic [15:0]             remaining_reg;
    logic                    started_reg;
    logic [15:0]             start_reg;
    logic [15:0]             wait_reg;
    cand_t                   cand_reg;
    cand_t                   cand_next;
    logic                    ready;
    logic                    take;
    logic signed [PRI_W:0]   aged;

    assign ready = valid_reg && (arrival_reg <= now) && (remaining_reg != 16'd0);
    assign take  = ready && (!cand_in.found || (prio_reg > cand_in.prio) ||
                   ((prio_reg == cand_in.prio) && (arrival_reg < cand_in.arrival)));
    assign aged  = {prio_reg[PRI_W-1], prio_reg} + $signed({9'd0, upd.aging});

    always_comb
    begin
        cand_next = cand_in;
        if (take)
        begin
            cand_next.found     = 1'b1;
            cand_next.prio      = prio_reg;
            cand_next.arrival   = arrival_reg;
            cand_next.idx       = MY_IDX;
            cand_next.id        = id_reg;
            cand_next.started   = started_reg;
            cand_next.start     = start_reg;
            cand_next.wait_cnt  = wait_reg;
            cand_next.remaining = remaining_reg;
        end
    end

    assign cand_out = cand_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            started_reg <= 1'b0;
        end
        else if (load_en)
        begin
            valid_reg   <= 1'b1;
            started_reg <= 1'b0;
        end
        else if (upd.en && ready && (upd.sel == MY_IDX))
        begin
            started_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        if (load_en)
        begin
            id_reg        <= load_id;
            prio_reg      <= load_prio;
            arrival_reg   <= load_arrival;
            remaining_reg <= load_burst;
            start_reg     <= 16'd0;
            wait_reg      <= 16'd0;
        end
        else if (upd.en && ready)
        begin
            if (upd.sel == MY_IDX)
            begin
                if (!started_reg)
                begin
                    start_reg <= upd.now;
                end
                remaining_reg <= remaining_reg - 16'd1;
            end
            else
            begin
                if (wait_reg != W16_MAX)
                begin
                    wait_reg <= wait_reg + 16'd1;
                end
                prio_reg <= (aged > PRI_MAX) ? PRI_MAX[PRI_W-1:0] : aged[PRI_W-1:0];
            end
        end
    end

endmodule
